[hw/rtl/vpa_pkg.sv]
// package for the variable partition allocator
// holds sizes, status codes, payload types and the segment entry type
// no dependencies
package vpa_pkg;

   localparam int MemUnits    = 1024;
   localparam int MaxSegments = 32;
   localparam int AddrWidth   = 10;
   localparam int LenWidth    = 11;
   localparam int IdxWidth    = $clog2(MaxSegments);
   localparam int CntWidth    = $clog2(MaxSegments + 1);

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD      = 3'd1;
   localparam logic [2:0] ST_NOSPACE  = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [7:0]          job_id;
      logic [LenWidth-1:0] request_size;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [AddrWidth-1:0] seg_address;
      logic [LenWidth-1:0]  seg_length;
   } rsp_type;

   typedef struct packed {
      logic [AddrWidth-1:0] start;
      logic [LenWidth-1:0]  length;
      logic [7:0]           owner;
      logic                 busy;
   } seg_type;

   typedef struct packed {
      logic                we;
      logic [IdxWidth-1:0] waddr;
      seg_type             wdata;
      logic [IdxWidth-1:0] raddr;
   } mem_ctl_type;

endpackage

[hw/rtl/variable_partition_allocator_top.sv]
// top level of the variable partition allocator
// sequencer around the segment table memory; depends on vpa_pkg, vpa_seg_ram
//
// The segment table lives in one single-port-read memory of MaxSegments
// entries. After reset an init pass writes entry zero, then the block is
// ready. Each valid request takes a scan of up to segment_count live entries
// (one read per cycle), then a table shift of up to segment_count entries for
// a split or a merge, one entry per cycle. A bad request gives its result in
// the cycle after the transfer. An allocate gives its result from the
// decision state after the scan, or, when it splits a segment, after the
// shift and the two split writes. A release gives its result from the
// decision state after the scan, then reads its neighbours, writes the merged
// free entry and shifts the table down before the next request. The worst
// case is a best fit split of entry zero with MaxSegments-1 live entries. One
// request is in work at a time, and the next request is taken only once the
// previous result has been transferred and the table update has finished.
module variable_partition_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vpa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vpa_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);
   import vpa_pkg::*;

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_SHUP  = 4'd4;
   localparam logic [3:0] S_SPLIT = 4'd5;
   localparam logic [3:0] S_RNB   = 4'd6;
   localparam logic [3:0] S_RPRV  = 4'd7;
   localparam logic [3:0] S_SHDN  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;
   localparam logic [3:0] S_RNXW  = 4'd10;

   localparam logic [CntWidth-1:0] CntOne = CntWidth'(1);
   localparam logic [CntWidth-1:0] CntMax = CntWidth'(MaxSegments);

   logic [3:0]          state_ff, state_in;
   logic                mode_ff;
   req_type             req_ff, req_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [CntWidth-1:0] idx_ff, idx_in;     // read index issued last cycle; write index in the down shift
   logic [CntWidth-1:0] ptr_ff, ptr_in;     // shift pointer, or count of removed entries on release
   logic [CntWidth-1:0] stop_ff, stop_in;   // shift end, or first destination of the down shift
   logic                found_ff, found_in;
   logic [IdxWidth-1:0] pick_ff, pick_in;
   seg_type             best_ff, best_in;
   seg_type             cur_ff, cur_in;     // picked entry being modified, or the free entry below on release
   logic [LenWidth-1:0] free_len_ff, free_len_in;
   logic [IdxWidth-1:0] dst_ff, dst_in;     // entry that the merged segment lands in
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   mem_ctl_type ctl;
   seg_type     rdata;

   vpa_seg_ram u_ram (
      .clock (clock),
      .ctl   (ctl),
      .rdata (rdata)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic rsp_type mk_rsp(logic [2:0] st, logic [AddrWidth-1:0] a,
                                      logic [LenWidth-1:0] l);
      rsp_type r;
      r.status      = st;
      r.seg_address = (st == ST_OK) ? a : '0;
      r.seg_length  = (st == ST_OK) ? l : '0;
      return r;
   endfunction

   always_comb begin
      logic    fits;
      seg_type w;
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      cur_in       = cur_ff;
      free_len_in  = free_len_ff;
      dst_in       = dst_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ctl          = '0;
      w            = '0;
      fits         = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_INIT: begin
            w.length  = LenWidth'(MemUnits);
            ctl.we    = 1'b1;
            ctl.wdata = w;
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in   = req_data;
               found_in = 1'b0;
               if (req_data.job_id == '0 ||
                   (req_data.kind == KIND_ALLOC && req_data.request_size == '0)) begin
                  rsp_in       = mk_rsp(ST_BAD, '0, '0);
                  rsp_valid_in = 1'b1;
               end else begin
                  ctl.raddr = '0;
                  idx_in    = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rdata holds entry idx_ff
            if (req_ff.kind == KIND_ALLOC) begin
               fits = !rdata.busy && rdata.length >= req_ff.request_size;
               if (fits && (!found_ff || (mode_ff && rdata.length < best_ff.length))) begin
                  found_in = 1'b1;
                  pick_in  = idx_ff[IdxWidth-1:0];
                  best_in  = rdata;
               end
               if (fits && !mode_ff) begin
                  state_in = S_DEC;
               end
            end else begin
               fits = rdata.busy && rdata.owner == req_ff.job_id;
               if (fits) begin
                  found_in = 1'b1;
                  pick_in  = idx_ff[IdxWidth-1:0];
                  best_in  = rdata;
                  state_in = S_DEC;
               end
            end
            if (state_in == S_SCAN) begin
               if (idx_ff + CntOne >= count_ff) begin
                  state_in = S_DEC;
               end else begin
                  idx_in    = idx_ff + CntOne;
                  ctl.raddr = idx_in[IdxWidth-1:0];
               end
            end
         end
         S_DEC: begin
            cur_in = best_ff;
            if (!found_ff) begin
               rsp_in = mk_rsp((req_ff.kind == KIND_ALLOC) ? ST_NOSPACE : ST_NOTFOUND,
                               '0, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (req_ff.kind == KIND_ALLOC) begin
               if (best_ff.length == req_ff.request_size) begin
                  w         = best_ff;
                  w.busy    = 1'b1;
                  w.owner   = req_ff.job_id;
                  ctl.we    = 1'b1;
                  ctl.waddr = pick_ff;
                  ctl.wdata = w;
                  rsp_in    = mk_rsp(ST_OK, best_ff.start, req_ff.request_size);
                  rsp_valid_in = 1'b1;
                  state_in  = S_IDLE;
               end else if (count_ff >= CntMax) begin
                  rsp_in       = mk_rsp(ST_FULL, '0, '0);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  // move entries pick+1..count-1 up by one, from the top
                  ptr_in  = count_ff;
                  stop_in = CntWidth'(pick_ff) + CntOne;
                  if (count_ff > CntWidth'(pick_ff) + CntOne) begin
                     ctl.raddr = IdxWidth'(count_ff - CntOne);
                     state_in  = S_SHUP;
                  end else begin
                     state_in = S_SPLIT;
                  end
               end
            end else begin
               rsp_in       = mk_rsp(ST_OK, best_ff.start, best_ff.length);
               rsp_valid_in = 1'b1;
               free_len_in  = best_ff.length;
               dst_in       = pick_ff;
               stop_in      = CntWidth'(pick_ff);  // index of first entry to drop later
               ptr_in       = '0;                  // number of entries removed
               if (CntWidth'(pick_ff) + CntOne < count_ff) begin
                  ctl.raddr = IdxWidth'(CntWidth'(pick_ff) + CntOne);
                  state_in  = S_RNB;
               end else begin
                  state_in = S_RNXW;
               end
            end
         end
         S_SHUP: begin
            // rdata holds entry ptr-1, write it to ptr
            ctl.we    = 1'b1;
            ctl.waddr = ptr_ff[IdxWidth-1:0];
            ctl.wdata = rdata;
            ptr_in    = ptr_ff - CntOne;
            if (ptr_in > stop_ff) begin
               ctl.raddr = IdxWidth'(ptr_in - CntOne);
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            if (ptr_ff == CntWidth'(pick_ff) + CntOne) begin
               w.start   = cur_ff.start + AddrWidth'(req_ff.request_size);
               w.length  = cur_ff.length - req_ff.request_size;
               ctl.we    = 1'b1;
               ctl.waddr = IdxWidth'(CntWidth'(pick_ff) + CntOne);
               ctl.wdata = w;
               ptr_in    = '0;
            end else begin
               w         = cur_ff;
               w.length  = req_ff.request_size;
               w.owner   = req_ff.job_id;
               w.busy    = 1'b1;
               ctl.we    = 1'b1;
               ctl.waddr = pick_ff;
               ctl.wdata = w;
               count_in  = count_ff + CntOne;
               rsp_in    = mk_rsp(ST_OK, cur_ff.start, req_ff.request_size);
               rsp_valid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_RNB: begin
            // rdata holds the entry above the released one
            if (!rdata.busy) begin
               free_len_in = free_len_ff + rdata.length;
               ptr_in      = ptr_ff + CntOne;
               stop_in     = CntWidth'(pick_ff) + CntOne;
            end
            state_in = S_RNXW;
         end
         S_RNXW: begin
            if (pick_ff != '0) begin
               ctl.raddr = pick_ff - IdxWidth'(1);
               state_in  = S_RPRV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RPRV: begin
            if (!rdata.busy) begin
               free_len_in = free_len_ff + rdata.length;
               dst_in      = pick_ff - IdxWidth'(1);
               cur_in      = rdata;
               stop_in     = CntWidth'(pick_ff);
               ptr_in      = ptr_ff + CntOne;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // write merged free entry, then shift the rest down by ptr entries
            w         = '0;
            w.start   = (dst_ff == pick_ff) ? best_ff.start : cur_ff.start;
            w.length  = free_len_ff;
            ctl.we    = 1'b1;
            ctl.waddr = dst_ff;
            ctl.wdata = w;
            count_in  = count_ff - ptr_ff;
            if (ptr_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               // first destination is stop, source is stop+ptr
               idx_in = stop_ff;
               if (stop_ff + ptr_ff < count_ff) begin
                  ctl.raddr = IdxWidth'(stop_ff + ptr_ff);
                  state_in  = S_SHDN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SHDN: begin
            ctl.we    = 1'b1;
            ctl.waddr = idx_ff[IdxWidth-1:0];
            ctl.wdata = rdata;
            idx_in    = idx_ff + CntOne;
            if (idx_in + ptr_ff < count_ff + ptr_ff) begin
               ctl.raddr = IdxWidth'(idx_in + ptr_ff);
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         mode_ff      <= 1'b0;
         count_ff     <= CntOne;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         ptr_ff       <= '0;
         stop_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         ptr_ff       <= ptr_in;
         stop_ff      <= stop_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      cur_ff      <= cur_in;
      free_len_ff <= free_len_in;
      dst_ff      <= dst_in;
      rsp_ff      <= rsp_in;
   end

endmodule

[hw/rtl/vpa_seg_ram.sv]
// segment table memory, one write and one registered read port
// depends on vpa_pkg
module vpa_seg_ram (
   input  logic                 clock,
   input  vpa_pkg::mem_ctl_type ctl,
   output vpa_pkg::seg_type     rdata
);
   import vpa_pkg::*;

   seg_type mem [MaxSegments];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata <= mem[ctl.raddr];
   end

endmodule

[tb/testbench.sv]
// testbench for variable_partition_allocator_top: directed table then random traffic
// checks every response against a segment table predictor; depends on vpa_pkg and the rtl
module testbench;
   import vpa_pkg::*;

   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic    chk;
      req_type rq;
      rsp_type rs;
   } vector_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;

   int      errors = 0;
   int      cycles = 0;
   int      sent = 0;
   int      got = 0;
   int      stall_pct = 0;
   rsp_type pending_rsp[$];
   vector_type directed[$];

   logic [AddrWidth-1:0] t_start[MaxSegments];
   logic [LenWidth-1:0]  t_len[MaxSegments];
   logic [7:0]           t_owner[MaxSegments];
   logic                 t_busy[MaxSegments];
   int                   t_count;
   logic                 fit_best;

   variable_partition_allocator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic table_reset();
      for (int i = 0; i < MaxSegments; i++) begin
         t_start[i] = '0; t_len[i] = '0; t_owner[i] = '0; t_busy[i] = 1'b0;
      end
      t_len[0] = LenWidth'(MemUnits);
      t_count = 1;
      fit_best = 1'b0;
   endtask

   task automatic drop_segment(int k);
      for (int j = k; j + 1 < t_count; j++) begin
         t_start[j] = t_start[j+1]; t_len[j] = t_len[j+1];
         t_owner[j] = t_owner[j+1]; t_busy[j] = t_busy[j+1];
      end
      t_count--;
      t_start[t_count] = '0; t_len[t_count] = '0;
      t_owner[t_count] = '0; t_busy[t_count] = 1'b0;
   endtask

   function automatic rsp_type make_rsp(logic [2:0] st, int a, int l);
      rsp_type r;
      r.status = st;
      r.seg_address = AddrWidth'(a);
      r.seg_length = LenWidth'(l);
      return r;
   endfunction

   task automatic allocate_predict(input req_type rq, output rsp_type r);
      int  pick;
      bit  found;
      pick = 0;
      found = 0;
      r = make_rsp(ST_BAD, 0, 0);
      if (rq.job_id == 0 || (rq.kind == KIND_ALLOC && rq.request_size == 0)) return;
      if (rq.kind == KIND_ALLOC) begin
         for (int i = 0; i < t_count; i++) begin
            if (t_busy[i] || t_len[i] < rq.request_size) continue;
            if (!fit_best) begin
               pick = i; found = 1; break;
            end
            if (!found || t_len[i] < t_len[pick]) begin
               pick = i; found = 1;
            end
         end
         if (!found) begin
            r = make_rsp(ST_NOSPACE, 0, 0);
         end else if (t_len[pick] == rq.request_size) begin
            t_busy[pick] = 1'b1; t_owner[pick] = rq.job_id;
            r = make_rsp(ST_OK, t_start[pick], rq.request_size);
         end else if (t_count >= MaxSegments) begin
            r = make_rsp(ST_FULL, 0, 0);
         end else begin
            for (int j = t_count; j > pick + 1; j--) begin
               t_start[j] = t_start[j-1]; t_len[j] = t_len[j-1];
               t_owner[j] = t_owner[j-1]; t_busy[j] = t_busy[j-1];
            end
            t_start[pick+1] = t_start[pick] + AddrWidth'(rq.request_size);
            t_len[pick+1] = t_len[pick] - rq.request_size;
            t_owner[pick+1] = '0; t_busy[pick+1] = 1'b0;
            t_len[pick] = rq.request_size; t_owner[pick] = rq.job_id; t_busy[pick] = 1'b1;
            t_count++;
            r = make_rsp(ST_OK, t_start[pick], rq.request_size);
         end
         return;
      end
      for (int i = 0; i < t_count; i++) begin
         if (t_busy[i] && t_owner[i] == rq.job_id) begin
            pick = i; found = 1; break;
         end
      end
      if (!found) begin
         r = make_rsp(ST_NOTFOUND, 0, 0);
         return;
      end
      r = make_rsp(ST_OK, t_start[pick], t_len[pick]);
      t_busy[pick] = 1'b0; t_owner[pick] = '0;
      if (pick + 1 < t_count && !t_busy[pick+1]) begin
         t_len[pick] += t_len[pick+1];
         drop_segment(pick + 1);
      end
      if (pick > 0 && !t_busy[pick-1]) begin
         t_len[pick-1] += t_len[pick];
         drop_segment(pick);
      end
   endtask

   task automatic send_request(input req_type rq, input int idle_pct, input bit chk,
                               input rsp_type want);
      rsp_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      allocate_predict(rq, r);
      if (chk && r != want) begin
         $error("directed row disagrees with predictor: expected %h got %h", want, r);
         errors++;
      end
      pending_rsp.push_back(r);
      req_data <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      csr_wdata <= m;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      fit_best = m;
   endtask

   function automatic req_type rand_req();
      req_type rq;
      int      p;
      p = $urandom_range(99);
      rq.kind = (p < 45) ? KIND_RELEASE : KIND_ALLOC;
      rq.job_id = ($urandom_range(49) == 0) ? 8'd0
                : ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      p = $urandom_range(99);
      if (p < 70) rq.request_size = LenWidth'($urandom_range(1, 48));
      else if (p < 90) rq.request_size = LenWidth'($urandom_range(1, 300));
      else rq.request_size = LenWidth'($urandom);
      return rq;
   endfunction

   function automatic vector_type row(bit chk, logic k, int j, int s,
                                      logic [2:0] st, int a, int l);
      vector_type v;
      v.chk = chk;
      v.rq.kind = k;
      v.rq.job_id = 8'(j);
      v.rq.request_size = LenWidth'(s);
      v.rs = make_rsp(st, a, l);
      return v;
   endfunction

   // response side: random stall and scoreboard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response with nothing outstanding: %h", rsp_data);
               errors++;
            end else begin
               automatic rsp_type w = pending_rsp.pop_front();
               if (rsp_data.status !== w.status) begin
                  $error("status expected %0d actual %0d", w.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.seg_address !== w.seg_address) begin
                  $error("seg_address expected %0d actual %0d", w.seg_address,
                         rsp_data.seg_address);
                  errors++;
               end
               if (rsp_data.seg_length !== w.seg_length) begin
                  $error("seg_length expected %0d actual %0d", w.seg_length,
                         rsp_data.seg_length);
                  errors++;
               end
            end
            got++;
         end
      end
      if (cycles > CycleLimit) begin
         $display("FAIL variable_partition_allocator_top");
         $finish;
      end
   end

   initial begin
      int sender_idle[4];
      int rcv_stall[4];
      sender_idle = '{0, 68, 0, 28};
      rcv_stall = '{0, 0, 68, 28};
      table_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, first fit after reset
      directed.push_back(row(1, KIND_ALLOC, 0, 5, ST_BAD, 0, 0));
      directed.push_back(row(1, KIND_ALLOC, 3, 0, ST_BAD, 0, 0));
      directed.push_back(row(1, KIND_RELEASE, 0, 9, ST_BAD, 0, 0));
      directed.push_back(row(1, KIND_RELEASE, 7, 0, ST_NOTFOUND, 0, 0));
      directed.push_back(row(1, KIND_ALLOC, 1, 2047, ST_NOSPACE, 0, 0));
      directed.push_back(row(1, KIND_ALLOC, 1, 1025, ST_NOSPACE, 0, 0));
      directed.push_back(row(1, KIND_ALLOC, 255, 1024, ST_OK, 0, 1024));
      directed.push_back(row(1, KIND_ALLOC, 2, 1, ST_NOSPACE, 0, 0));
      directed.push_back(row(1, KIND_RELEASE, 255, 0, ST_OK, 0, 1024));
      directed.push_back(row(1, KIND_ALLOC, 1, 100, ST_OK, 0, 100));
      directed.push_back(row(1, KIND_ALLOC, 2, 50, ST_OK, 100, 50));
      directed.push_back(row(1, KIND_ALLOC, 1, 30, ST_OK, 150, 30));
      directed.push_back(row(0, KIND_ALLOC, 3, 20, ST_OK, 0, 0));
      directed.push_back(row(1, KIND_RELEASE, 1, 1234, ST_OK, 0, 100));
      directed.push_back(row(1, KIND_ALLOC, 4, 100, ST_OK, 0, 100));
      directed.push_back(row(0, KIND_RELEASE, 2, 0, ST_OK, 0, 0));
      directed.push_back(row(0, KIND_RELEASE, 1, 0, ST_OK, 0, 0));
      foreach (directed[i])
         send_request(directed[i].rq, 0, directed[i].chk, directed[i].rs);
      // fill the table with single units, then try a split
      for (int i = 0; i < 34; i++)
         send_request('{KIND_ALLOC, 8'(i % 5 + 1), 11'd1}, 0, 0, '0);
      wait_drained();
      write_mode(1'b1);
      for (int i = 0; i < 40; i++)
         send_request('{KIND_RELEASE, 8'(i % 6 + 1), 11'd0}, 0, 0, '0);

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         write_mode(ph[0]);
         stall_pct = rcv_stall[ph % 4];
         for (int n = 0; n < 130; n++)
            send_request(rand_req(), sender_idle[ph % 4], 0, '0);
      end

      wait_drained();
      $display("covered %0d requests and %0d responses in both fit modes", sent, got);
      $display("four handshake pressure phases, table full, no space and bad requests");
      if (errors == 0)
         $display("PASS variable_partition_allocator_top");
      else
         $display("FAIL variable_partition_allocator_top");
      $finish;
   end
endmodule
